[sv/tsm_pkg.sv]
// ============================================================================
// tsm_pkg
// Shared types, constants and helpers for the toggle handshake serial mailbox.
// ============================================================================
package tsm_pkg;

    // Largest block length in bytes and number of serial channels.
    localparam int MAX_BYTES  = 22;
    localparam int CHANNELS   = 2;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Fixed field widths of the transaction payloads.
    localparam int CH_W       = 1;
    localparam int STAT_W     = 16;
    localparam int HOST_W     = 8;
    localparam int CTRL_W     = 8;
    localparam int FLEN_W     = 6;   // length field in control bits 7:2
    localparam int OLEN_W     = 5;   // lengths reported in the result
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // Bit positions in the status and control words.
    localparam int ACK_POS    = 0;   // status: tx accepted, control: rx ack
    localparam int SEND_POS   = 1;   // status: rx request, control: send toggle
    localparam int LEN_LO     = 2;
    localparam int LEN_HI     = 7;

    typedef logic [CH_IDX_W-1:0] t_ch_idx;

    // One accepted input transaction.
    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic              operational;
        logic [STAT_W-1:0] status_word;
        logic [HOST_W-1:0] host_tx_len;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic [CTRL_W-1:0] ctrl_word;
        logic              tx_busy;
        logic              rx_toggle;
        logic [OLEN_W-1:0] rx_len;
        logic              rx_capture;
        logic              tx_launch;
        logic [OLEN_W-1:0] tx_len_sent;
    } t_result;

    // Handshake state kept for each channel.
    typedef struct packed {
        logic [CTRL_W-1:0] ctrl;
        logic              send_tgl;
        logic              last_req;
        logic              last_acc;
        logic              busy;
        logic              ready_tgl;
        logic [OLEN_W-1:0] rx_len;
    } t_chan_state;

    // Saturate a length at the block size.
    function automatic logic [FLEN_W-1:0] clamp_len(input logic [HOST_W-1:0] v);
        logic [FLEN_W-1:0] r;
        if (v > HOST_W'(MAX_BYTES)) begin
            r = FLEN_W'(MAX_BYTES);
        end else begin
            r = v[FLEN_W-1:0];
        end
        return r;
    endfunction

endpackage

[sv/tsm_in_stage.sv]
// ============================================================================
// tsm_in_stage
// Input register: holds one accepted transaction until the engine takes it.
// ============================================================================
module tsm_in_stage
    import tsm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_out_free,
    output logic  o_valid,
    output logic  o_adv,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // The held transaction moves on when the result register can take it.
    assign o_adv   = r_valid && i_out_free;
    assign o_ready = !r_valid || o_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, loaded on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[sv/tsm_engine.sv]
// ============================================================================
// tsm_engine
// Per-channel handshake state and the single-pass receive/transmit update.
// ============================================================================
module tsm_engine
    import tsm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    output t_result o_res
);

    t_chan_state r_state [CHANNELS];
    t_chan_state cur;
    t_chan_state n_state;
    t_ch_idx     ch_idx;
    logic        in_range;
    logic        acc_bit;
    logic        req_bit;
    logic        capture;
    logic        launch;
    logic [FLEN_W-1:0] rx_clamp;
    logic [FLEN_W-1:0] tx_clamp;

    assign in_range = int'(i_item.channel) < CHANNELS;
    assign ch_idx   = t_ch_idx'(i_item.channel);
    assign cur      = r_state[ch_idx];
    assign acc_bit  = i_item.status_word[ACK_POS];
    assign req_bit  = i_item.status_word[SEND_POS];
    assign rx_clamp = clamp_len(HOST_W'(i_item.status_word[LEN_HI:LEN_LO]));
    assign tx_clamp = clamp_len(i_item.host_tx_len);

    // Receive phase, then transmit phase, on the selected channel.
    always_comb begin
        n_state = cur;
        capture = 1'b0;
        launch  = 1'b0;
        if (i_item.operational) begin
            // A toggle of the accept bit means the terminal took our block.
            if (acc_bit != cur.last_acc) begin
                n_state.last_acc = acc_bit;
                n_state.busy     = 1'b0;
            end
            // A toggle of the request bit means a new receive block.
            if (req_bit != cur.last_req) begin
                n_state.last_req      = req_bit;
                n_state.rx_len        = rx_clamp[OLEN_W-1:0];
                n_state.ready_tgl     = !cur.ready_tgl;
                n_state.ctrl[ACK_POS] = req_bit;
                capture               = 1'b1;
            end
        end
        // Launch a transmit block when there is data and the channel is free.
        if ((tx_clamp != '0) && !n_state.busy) begin
            n_state.send_tgl            = !cur.send_tgl;
            n_state.ctrl[LEN_HI:LEN_LO] = tx_clamp;
            n_state.ctrl[SEND_POS]      = !cur.send_tgl;
            n_state.busy                = 1'b1;
            launch                      = 1'b1;
        end
    end

    // Result fields; an out-of-range channel gives an all-zero result.
    always_comb begin
        o_res = '0;
        if (in_range) begin
            o_res.ctrl_word   = n_state.ctrl;
            o_res.tx_busy     = n_state.busy;
            o_res.rx_toggle   = n_state.ready_tgl;
            o_res.rx_len      = n_state.rx_len;
            o_res.rx_capture  = capture;
            o_res.tx_launch   = launch;
            o_res.tx_len_sent = launch ? tx_clamp[OLEN_W-1:0] : '0;
        end
    end

    // State update of the selected channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_state[k] <= '0;
            end
        end else if (i_adv && in_range) begin
            r_state[ch_idx] <= n_state;
        end
    end

    // A launch leaves the channel busy in the stored state.
    a_launch_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.tx_launch) |=> r_state[$past(ch_idx)].busy)
        else $error("launch did not leave channel busy");

    // A launch always carries a nonzero length that also sits in the control word.
    a_launch_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.tx_launch) |->
        (o_res.tx_len_sent != '0) && (o_res.ctrl_word[LEN_HI:LEN_LO] == tx_clamp))
        else $error("launch length mismatch");

    // No capture is reported while the receive phase is skipped.
    a_no_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_item.operational) |-> !o_res.rx_capture)
        else $error("capture without operational");

    // A capture flips the ready toggle of the stored state.
    a_capture_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.rx_capture) |=>
        (r_state[$past(ch_idx)].ready_tgl != $past(cur.ready_tgl)))
        else $error("capture did not flip the receive toggle");

endmodule

[sv/toggle_handshake_serial_mailbox_unit.sv]
// ============================================================================
// toggle_handshake_serial_mailbox_unit
// Two-channel toggle handshake controller for a serial mailbox.
// ============================================================================
// A transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle unless the output stalls; the input register
// and the result register each hold one, so one more is taken while a result waits.
// Reset: synchronous, active low; clears both valid flags and all channel state.
module toggle_handshake_serial_mailbox_unit
    import tsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: [0] operational, [16:1] status_word, [24:17] host_tx_len, [31:25] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // tuser: [0] channel
    input  logic [CH_W-1:0]       i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: [7:0] ctrl_word, [8] tx_busy, [9] rx_toggle, [14:10] rx_len,
    //        [15] rx_capture, [16] tx_launch, [21:17] tx_len_sent, [23:22] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    t_item   in_item;
    t_item   held_item;
    t_result res;
    t_result r_res;
    logic    r_out_valid;
    logic    out_free;
    logic    held_valid;
    logic    adv;

    // Unpack the input transaction.
    assign in_item.channel     = i_s_tuser;
    assign in_item.operational = i_s_tdata[0];
    assign in_item.status_word = i_s_tdata[16:1];
    assign in_item.host_tx_len = i_s_tdata[24:17];

    assign out_free = !r_out_valid || i_m_tready;

    tsm_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_valid    (held_valid),
        .o_adv      (adv),
        .o_item     (held_item)
    );

    tsm_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (held_item),
        .o_res   (res)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    // Pack the result transaction.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_res.tx_len_sent, r_res.tx_launch, r_res.rx_capture,
                         r_res.rx_len, r_res.rx_toggle, r_res.tx_busy, r_res.ctrl_word};

    // The engine only advances with a held transaction.
    a_adv_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> held_valid)
        else $error("advance without held transaction");

    // A stalled result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !adv)
        else $error("result register overwritten");

    // Every advance produces a valid result on the next cycle.
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("advance lost a result");

endmodule

[tb/toggle_mailbox_check.sv]
// ============================================================================
// toggle_mailbox_check
// Watches both stream channels of the mailbox unit, predicts every result
// from the accepted input transactions and compares the results field by
// field in arrival order.
// ============================================================================
module toggle_mailbox_check
    import tsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // tdata: [0] operational, [16:1] status_word, [24:17] host_tx_len, [31:25] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // tuser: [0] channel
    input  logic [CH_W-1:0]       i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: [7:0] ctrl_word, [8] tx_busy, [9] rx_toggle, [14:10] rx_len,
    //        [15] rx_capture, [16] tx_launch, [21:17] tx_len_sent, [23:22] zero
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_items_seen,
    output int                    o_results_checked,
    output int                    o_launches,
    output int                    o_captures
);
    timeunit 1ns;
    timeprecision 1ps;

    // Handshake context of one channel as the checker tracks it.
    typedef struct {
        logic [CTRL_W-1:0] ctl;
        logic              send_tgl;
        logic              req_seen;
        logic              acc_seen;
        logic              busy;
        logic              ready_tgl;
        logic [OLEN_W-1:0] rlen;
    } t_chan_ctx;

    t_chan_ctx chan_ctx [CHANNELS];
    t_result   expected_results [$];

    int fails           = 0;
    int items_seen      = 0;
    int results_checked = 0;
    int launches        = 0;
    int captures        = 0;

    // Runs the receive and transmit phases for one transaction and returns
    // the result that the unit must produce for it.
    function automatic t_result predict_step(input t_item it);
        t_result           r;
        logic              acc;
        logic              req;
        logic [FLEN_W-1:0] len;
        int                ch;
        r  = '0;
        ch = int'(it.channel);
        if (ch >= CHANNELS) return r;

        // Receive phase: only while the terminal is operational.
        if (it.operational) begin
            acc = it.status_word[ACK_POS];
            req = it.status_word[SEND_POS];
            if (acc != chan_ctx[ch].acc_seen) begin
                chan_ctx[ch].acc_seen = acc;
                chan_ctx[ch].busy     = 1'b0;
            end
            if (req != chan_ctx[ch].req_seen) begin
                len = (it.status_word[LEN_HI:LEN_LO] > FLEN_W'(MAX_BYTES)) ?
                      FLEN_W'(MAX_BYTES) : it.status_word[LEN_HI:LEN_LO];
                chan_ctx[ch].req_seen     = req;
                chan_ctx[ch].rlen         = len[OLEN_W-1:0];
                chan_ctx[ch].ready_tgl    = ~chan_ctx[ch].ready_tgl;
                chan_ctx[ch].ctl[ACK_POS] = req;
                r.rx_capture              = 1'b1;
            end
        end

        // Transmit phase: a free channel launches any nonzero host length.
        len = (it.host_tx_len > HOST_W'(MAX_BYTES)) ?
              FLEN_W'(MAX_BYTES) : it.host_tx_len[FLEN_W-1:0];
        if (len != '0 && !chan_ctx[ch].busy) begin
            chan_ctx[ch].send_tgl            = ~chan_ctx[ch].send_tgl;
            chan_ctx[ch].ctl[LEN_HI:LEN_LO]  = len;
            chan_ctx[ch].ctl[SEND_POS]       = chan_ctx[ch].send_tgl;
            chan_ctx[ch].busy                = 1'b1;
            r.tx_launch                      = 1'b1;
            r.tx_len_sent                    = len[OLEN_W-1:0];
        end

        r.ctrl_word = chan_ctx[ch].ctl;
        r.tx_busy   = chan_ctx[ch].busy;
        r.rx_toggle = chan_ctx[ch].ready_tgl;
        r.rx_len    = chan_ctx[ch].rlen;
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    // Both channels are sampled at the clock edge, before any update of it.
    always @(posedge i_clk) begin : watch
        t_item   it;
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                chan_ctx[k] = '{default: '0};
            end
            expected_results.delete();
        end else begin
            // A result that arrives is matched against the oldest prediction.
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0d ns: result 0x%06h arrived with no transaction pending",
                             $time, i_m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("ctrl_word",   want.ctrl_word,   i_m_tdata[7:0]);
                    check_field("tx_busy",     want.tx_busy,     i_m_tdata[8]);
                    check_field("rx_toggle",   want.rx_toggle,   i_m_tdata[9]);
                    check_field("rx_len",      want.rx_len,      i_m_tdata[14:10]);
                    check_field("rx_capture",  want.rx_capture,  i_m_tdata[15]);
                    check_field("tx_launch",   want.tx_launch,   i_m_tdata[16]);
                    check_field("tx_len_sent", want.tx_len_sent, i_m_tdata[21:17]);
                    check_field("padding",     0,                i_m_tdata[23:22]);
                    results_checked++;
                end
            end
            // Every accepted input transaction produces exactly one result.
            if (i_s_tvalid && i_s_tready) begin
                it.channel     = i_s_tuser;
                it.operational = i_s_tdata[0];
                it.status_word = i_s_tdata[16:1];
                it.host_tx_len = i_s_tdata[24:17];
                want = predict_step(it);
                if (want.tx_launch) launches++;
                if (want.rx_capture) captures++;
                expected_results.push_back(want);
                items_seen++;
            end
        end
        o_pending         <= expected_results.size();
        o_fail_count      <= fails;
        o_items_seen      <= items_seen;
        o_results_checked <= results_checked;
        o_launches        <= launches;
        o_captures        <= captures;
    end

endmodule

[tb/toggle_handshake_serial_mailbox_unit_tb.sv]
// ============================================================================
// toggle_handshake_serial_mailbox_unit_tb
// Drives directed and random servo-cycle transactions into the mailbox unit
// with random gaps and stalls on both streams, and reports the verdict from
// the result checker.
// ============================================================================
module toggle_handshake_serial_mailbox_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsm_pkg::*;

    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_PER_PHASE = 450;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int DRAIN_CYCLES     = 8;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic [CH_W-1:0]       i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    int fail_count;
    int pending;
    int items_seen;
    int results_checked;
    int launches;
    int captures;
    int quiet_cycles = 0;

    // Shared control between the stimulus and the result sink.
    logic                random_idle   = 1'b1;
    logic                long_hold_req = 1'b0;
    // Toggle bits of the simulated terminal, per channel.
    logic [CHANNELS-1:0] term_acc      = '0;
    logic [CHANNELS-1:0] term_req      = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    toggle_handshake_serial_mailbox_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    toggle_mailbox_check result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_s_tuser         (i_s_tuser),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_items_seen      (items_seen),
        .o_results_checked (results_checked),
        .o_launches        (launches),
        .o_captures        (captures)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one transaction and returns at the edge that accepts it.
    task automatic send_item(input logic [CH_W-1:0] ch, input logic oper,
                             input logic [STAT_W-1:0] stat, input logic [HOST_W-1:0] host);
        int gap;
        gap = random_idle ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= ch;
        i_s_tdata  <= IN_DATA_W'({host, stat, oper});
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Mostly terminal-like status words with occasional toggles, plus some
    // fully random transactions as noise.
    task automatic send_random_item();
        logic [CH_W-1:0]   ch;
        logic              oper;
        logic [STAT_W-1:0] stat;
        logic [HOST_W-1:0] host;
        logic [FLEN_W-1:0] len;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            ch   = CH_W'($urandom);
            oper = 1'($urandom);
            stat = STAT_W'($urandom);
            host = HOST_W'($urandom);
        end else begin
            ch   = CH_W'($urandom_range(0, CHANNELS - 1));
            oper = ($urandom_range(0, 15) != 0);
            if ($urandom_range(0, 3) == 0) term_acc[ch] = ~term_acc[ch];
            if ($urandom_range(0, 3) == 0) term_req[ch] = ~term_req[ch];
            len  = ($urandom_range(0, 9) == 0) ? FLEN_W'($urandom_range(MAX_BYTES + 1, 63))
                                                : FLEN_W'($urandom_range(0, MAX_BYTES));
            stat = {8'($urandom), len, term_req[ch], term_acc[ch]};
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                host = '0;
            end else if (pick < 9) begin
                host = HOST_W'($urandom_range(1, MAX_BYTES));
            end else begin
                host = HOST_W'($urandom_range(MAX_BYTES + 1, 255));
            end
        end
        send_item(ch, oper, stat, host);
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Result sink: random ready pattern, a steady ready when idling is off,
    // and one long hold-off on request.
    initial begin : result_sink
        int burst;
        int stall;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!random_idle) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                burst = $urandom_range(1, 8);
                i_m_tready <= 1'b1;
                repeat (burst) @(posedge i_clk);
                stall = pick_gap();
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0d ns: watchdog expired after %0d cycles without a transaction",
                     $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_n;
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: saturation, busy blocking, both toggles at once,
        // skipped receive phase and both channels.
        send_item(1'b0, 1'b1, 16'h0000, 8'd0);
        send_item(1'b0, 1'b1, 16'h0000, 8'd255);
        send_item(1'b0, 1'b1, 16'h0000, 8'd22);
        send_item(1'b0, 1'b1, 16'h0001, 8'd5);
        send_item(1'b0, 1'b0, 16'h0002, 8'd3);
        send_item(1'b0, 1'b1, 16'hFFFF, 8'd0);
        send_item(1'b0, 1'b1, 16'hFF54, 8'd23);
        send_item(1'b0, 1'b1, 16'h0059, 8'd1);
        send_item(1'b0, 1'b1, 16'h005E, 8'd0);
        send_item(1'b1, 1'b1, 16'h0000, 8'd1);
        send_item(1'b1, 1'b1, 16'h0003, 8'd128);
        send_item(1'b1, 1'b0, 16'hFFFF, 8'd0);
        send_item(1'b1, 1'b1, 16'h00FC, 8'd0);
        send_item(1'b1, 1'b1, 16'h0000, 8'd0);
        send_item(1'b1, 1'b1, 16'h0002, 8'd255);
        send_item(1'b0, 1'b1, 16'h0000, 8'd22);
        send_item(1'b1, 1'b1, 16'h0001, 8'd22);
        send_item(1'b0, 1'b1, 16'hAA03, 8'd55);
        send_item(1'b1, 1'b1, 16'h5500, 8'd170);
        wait_for_results();

        // Random phases: gaps, no gaps, a long output hold-off, gaps again.
        for (phase_n = 0; phase_n < 4; phase_n++) begin
            random_idle = (phase_n != 1);
            if (phase_n == 2) long_hold_req = 1'b1;
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                send_random_item();
            end
            wait_for_results();
        end

        // Give a stray result the chance to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d transactions on both channels, %0d results compared.",
                 items_seen, results_checked);
        $display("Saw %0d launches and %0d captures under random gaps and a long stall.",
                 launches, captures);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/tsm_pkg.sv
sv/tsm_in_stage.sv
sv/tsm_engine.sv
sv/toggle_handshake_serial_mailbox_unit.sv
tb/toggle_mailbox_check.sv
tb/toggle_handshake_serial_mailbox_unit_tb.sv
